### hw/rtl/ofa_pkg.sv
// Shared types and constants for the overlap-add FIR filter.
// Used by the tap cells, the multiply-accumulate unit and the top level.
package ofa_pkg;

   // Filter dimensions.
   localparam int MAX_TAPS = 64;
   localparam int CNT_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int SMP_W    = 16;
   localparam int TAP_W    = 16;
   localparam int IDX_W    = 6;
   localparam int TC_W     = 7;
   localparam int PROD_W   = SMP_W + TAP_W;
   localparam int ACC_W    = PROD_W + CNT_W + 1;
   localparam int FRAC_W   = 15;

   // Stream payload layout.
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   // Command codes carried in req_tuser.
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   // Register map.
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic REG_TAP_COUNT = 1'b0;

   // Per-cycle control for every cell of the tap chain.
   typedef struct packed {
      logic shift;
      logic rotate;
   } ofa_cell_ctrl_type;

   // Control for the multiply-accumulate unit.
   typedef struct packed {
      logic clear;
      logic use_tap;
   } ofa_mac_ctrl_type;

endpackage

### hw/rtl/ofa_cell.sv
// One cell of the tap chain: holds one history sample and one coefficient.
// Depends on ofa_pkg for widths and the control struct.
module ofa_cell
   import ofa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  ofa_cell_ctrl_type        ctrl,
   input  logic                     load_en,
   input  logic signed [TAP_W-1:0]  load_tap,
   input  logic signed [SMP_W-1:0]  prev_hist,
   input  logic signed [SMP_W-1:0]  next_hist,
   input  logic signed [TAP_W-1:0]  next_tap,
   output logic signed [SMP_W-1:0]  hist,
   output logic signed [TAP_W-1:0]  tap
);

   logic signed [SMP_W-1:0] hist_ff, hist_in;
   logic signed [TAP_W-1:0] tap_ff, tap_in;

   // A shift moves history one place down the line; a rotate passes the
   // whole pair one place toward cell zero; otherwise load_en writes the coefficient.
   always_comb begin
      hist_in = hist_ff;
      tap_in  = tap_ff;
      if (ctrl.shift) begin
         hist_in = prev_hist;
      end else if (ctrl.rotate) begin
         hist_in = next_hist;
         tap_in  = next_tap;
      end else if (load_en) begin
         tap_in = load_tap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
         tap_ff  <= '0;
      end else begin
         hist_ff <= hist_in;
         tap_ff  <= tap_in;
      end
   end

   assign hist = hist_ff;
   assign tap  = tap_ff;

endmodule

### hw/rtl/ofa_mac.sv
// Multiply-accumulate unit fed by cell zero of the tap chain, with the
// floor and saturation of the result. Depends on ofa_pkg.
module ofa_mac
   import ofa_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  ofa_mac_ctrl_type            ctrl,
   input  logic signed [TAP_W-1:0]     tap,
   input  logic signed [SMP_W-1:0]     hist,
   output logic signed [RSP_DATA_W-1:0] filtered
);

   localparam int SHR_W = ACC_W - FRAC_W;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     use_ff, use_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [SHR_W-1:0]  floored;

   // Product stage, then accumulate stage.
   always_comb begin
      prod_in = tap * hist;
      use_in  = ctrl.use_tap;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (use_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_ff <= 1'b0;
         acc_ff <= '0;
      end else begin
         use_ff <= use_in;
         acc_ff <= acc_in;
      end
      prod_ff <= prod_in;
   end

   // An arithmetic shift rounds toward minus infinity.
   assign floored = SHR_W'(acc_ff >>> FRAC_W);

   always_comb begin
      if (floored > SHR_W'(32767)) begin
         filtered = 16'sh7FFF;
      end else if (floored < -SHR_W'(32768)) begin
         filtered = 16'sh8000;
      end else begin
         filtered = RSP_DATA_W'(floored);
      end
   end

endmodule

### hw/rtl/overlap_add_fir_filter.sv
// Direct-form FIR: a sample beat is accepted in the idle state; the run state then rotates
// the tap chain once while the MAC takes each tap, and the flush and finish states register
// the result. The single MAC sees cell zero while the chain rotates once, so no new beat is
// taken until the result is registered. A load beat is taken in idle and gives no result.
// Reset (synchronous) clears history, coefficients and control; tap_count becomes 64.
module overlap_add_fir_filter
   import ofa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: sample[15:0], tap_index[21:16], tap_value[37:22], zero pad [39:38]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: cmd[0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rsp_tdata: filtered[15:0]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FLUSH, ST_FINISH} state_type;

   localparam int CMP_W = (CNT_W + 1 > TC_W) ? CNT_W + 1 : TC_W;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [TC_W-1:0]         tap_count_ff, tap_count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic signed [SMP_W-1:0] req_sample;
   logic [IDX_W-1:0]        req_tap_index;
   logic signed [TAP_W-1:0] req_tap_value;
   logic                    req_accept;
   logic                    csr_write;
   logic [CMP_W-1:0]        taps_used;
   logic                    use_tap;

   ofa_cell_ctrl_type       cell_ctrl;
   ofa_mac_ctrl_type        mac_ctrl;
   logic signed [SMP_W-1:0] hist [MAX_TAPS];
   logic signed [TAP_W-1:0] tap  [MAX_TAPS];
   logic signed [RSP_DATA_W-1:0] filtered;

   // Unpack the request beat.
   assign req_sample    = req_tdata[15:0];
   assign req_tap_index = req_tdata[21:16];
   assign req_tap_value = req_tdata[37:22];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // Configuration port: one register, decoded by its word address.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_TAP_COUNT) ?
                       CSR_DATA_W'(tap_count_ff) : '0;

   // Taps in use, clamped to the chain length.
   assign taps_used = (CMP_W'(tap_count_ff) > CMP_W'(MAX_TAPS)) ?
                      CMP_W'(MAX_TAPS) : CMP_W'(tap_count_ff);
   assign use_tap   = (state_ff == ST_RUN) && (CMP_W'(cnt_ff) < taps_used);

   // Chain and MAC control.
   assign cell_ctrl.shift  = req_accept && (req_tuser == CMD_SAMPLE);
   assign cell_ctrl.rotate = (state_ff == ST_RUN);
   assign mac_ctrl.clear   = cell_ctrl.shift;
   assign mac_ctrl.use_tap = use_tap;

   // The tap chain: shift feeds from the lower neighbor, rotate from the upper one.
   for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
      logic signed [SMP_W-1:0] prev_hist;
      logic                    load_en;
      if (k == 0) begin : g_first
         assign prev_hist = req_sample;
      end else begin : g_rest
         assign prev_hist = hist[k-1];
      end
      assign load_en = req_accept && (req_tuser == CMD_LOAD) && (int'(req_tap_index) == k);
      ofa_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .load_en   (load_en),
         .load_tap  (req_tap_value),
         .prev_hist (prev_hist),
         .next_hist (hist[(k + 1) % MAX_TAPS]),
         .next_tap  (tap[(k + 1) % MAX_TAPS]),
         .hist      (hist[k]),
         .tap       (tap[k])
      );
   end

   ofa_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (mac_ctrl),
      .tap      (tap[0]),
      .hist     (hist[0]),
      .filtered (filtered)
   );

   // Sequencer next-state and output register.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      tap_count_in = tap_count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (csr_write && (csr_paddr[2] == REG_TAP_COUNT)) begin
         tap_count_in = csr_pwdata[TC_W-1:0];
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (cell_ctrl.shift) begin
               state_in = ST_RUN;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MAX_TAPS - 1)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = filtered;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         tap_count_ff <= TC_W'(64);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         tap_count_ff <= tap_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A sample beat always starts a full rotation from step zero.
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tuser == CMD_SAMPLE) |=> (state_ff == ST_RUN && cnt_ff == '0))
      else $error("sample beat did not start the rotation");

   // The last rotation step hands over to the flush cycle.
   a_flush: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && cnt_ff == CNT_W'(MAX_TAPS - 1)) |=> (state_ff == ST_FLUSH))
      else $error("rotation did not end after one full turn");

   // Leaving the finish cycle always presents a result beat.
   a_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && state_in == ST_IDLE) |=> rsp_tvalid)
      else $error("finished sample produced no result beat");

endmodule
